### design/asa_pkg.sv
// ============================================================================
// asa_pkg
// Shared field widths, command and status codes, and the stack operation
// struct for the aligned stack allocator.
// ============================================================================
`default_nettype none

package asa_pkg;

    localparam int CMD_W     = 2;
    localparam int SIZE_W    = 16;
    localparam int ALIGN_W   = 16;
    localparam int STATUS_W  = 3;
    localparam int OUT_OFF_W = 13;
    localparam int LIVE_W    = 4;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 64;

    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_STACK_FULL  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_REQUEST = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ARENA_FULL  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_POP_EMPTY   = 3'd4;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } stack_op_t;

endpackage

`default_nettype wire

### design/aligned_stack_allocator_core.sv
// ============================================================================
// aligned_stack_allocator_core
// LIFO bump allocator over a fixed arena with power-of-two aligned pushes.
//
//  port group  dir  fields (lsb first)
//  s_*         in   command[1:0] object_size[17:2] alignment[33:18]
//  m_*         out  status[2:0] object_offset[15:3] top_offset[28:16]
//                   top_valid[29] previous_offset[42:30] previous_valid[43]
//                   live_count[47:44] used_bytes[60:48]
//
// One item per cycle while the output is not stalled; its result is registered and shows in the next cycle.
// Throughput is set by the single output register: s_tready is high while
// that register is empty or being taken. Reset leaves the stack empty and
// the arena unused. A stalled result holds and blocks new items.
// ============================================================================
`default_nettype none

module aligned_stack_allocator_core #(
    parameter int ARENA_BYTES = 4096,
    parameter int MAX_ALIGN   = 64,
    parameter int STACK_DEPTH = 8
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output      logic                               s_tready,
    // command, object_size, alignment
    input  wire logic [asa_pkg::IN_DATA_W-1:0]      s_tdata,
    output      logic                               m_tvalid,
    input  wire logic                               m_tready,
    // status, object_offset, top_offset, top_valid, previous_offset,
    // previous_valid, live_count, used_bytes
    output      logic [asa_pkg::OUT_DATA_W-1:0]     m_tdata
);

    localparam int OFF_W     = $clog2(ARENA_BYTES + 1);
    localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int OUT_OFF_W = asa_pkg::OUT_OFF_W;
    localparam int LIVE_W    = asa_pkg::LIVE_W;

    logic [asa_pkg::CMD_W-1:0]    command;
    logic [asa_pkg::SIZE_W-1:0]   object_size;
    logic [asa_pkg::ALIGN_W-1:0]  alignment;
    logic                         accept;

    logic [asa_pkg::STATUS_W-1:0] status;
    asa_pkg::stack_op_t           op;
    logic [OFF_W-1:0]             push_start;
    logic [OFF_W-1:0]             push_fill;
    logic [CNT_W-1:0]             count;
    logic [OFF_W-1:0]             fill;
    logic [CNT_W-1:0]             count_next;
    logic [OFF_W-1:0]             fill_next;
    logic [OFF_W-1:0]             top_start_next;
    logic [OFF_W-1:0]             prev_start_next;

    logic                         out_valid_reg;
    logic [asa_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic                         top_valid;
    logic                         prev_valid;
    logic [OUT_OFF_W-1:0]         object_offset;
    logic [OUT_OFF_W-1:0]         top_offset;
    logic [OUT_OFF_W-1:0]         previous_offset;

    assign command     = s_tdata[1:0];
    assign object_size = s_tdata[17:2];
    assign alignment   = s_tdata[33:18];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    asa_req_decode #(
        .ARENA_BYTES (ARENA_BYTES),
        .MAX_ALIGN   (MAX_ALIGN),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_decode (
        .command     (command),
        .object_size (object_size),
        .alignment   (alignment),
        .fill        (fill),
        .count       (count),
        .status      (status),
        .op          (op),
        .push_start  (push_start),
        .push_fill   (push_fill)
    );

    asa_entry_stack #(
        .ARENA_BYTES (ARENA_BYTES),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step            (accept),
        .op              (op),
        .push_start      (push_start),
        .push_fill       (push_fill),
        .count           (count),
        .fill            (fill),
        .count_next      (count_next),
        .fill_next       (fill_next),
        .top_start_next  (top_start_next),
        .prev_start_next (prev_start_next)
    );

    assign top_valid       = count_next >= CNT_W'(1);
    assign prev_valid      = count_next >= CNT_W'(2);
    assign object_offset   = op.push ? OUT_OFF_W'(push_start) : '0;
    assign top_offset      = top_valid ? OUT_OFF_W'(top_start_next) : '0;
    assign previous_offset = prev_valid ? OUT_OFF_W'(prev_start_next) : '0;

    always_comb begin
        out_data_next        = '0;
        out_data_next[2:0]   = status;
        out_data_next[15:3]  = object_offset;
        out_data_next[28:16] = top_offset;
        out_data_next[29]    = top_valid;
        out_data_next[42:30] = previous_offset;
        out_data_next[43]    = prev_valid;
        out_data_next[47:44] = LIVE_W'(count_next);
        out_data_next[60:48] = OUT_OFF_W'(fill_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_tready) begin
            out_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

### design/asa_req_decode.sv
// ============================================================================
// asa_req_decode
// Checks one request against the stack state and computes the aligned start
// and the new fill offset of a push.
// ============================================================================
`default_nettype none

module asa_req_decode #(
    parameter int ARENA_BYTES = 4096,
    parameter int MAX_ALIGN   = 64,
    parameter int STACK_DEPTH = 8
) (
    input  wire logic [asa_pkg::CMD_W-1:0]                 command,
    input  wire logic [asa_pkg::SIZE_W-1:0]                object_size,
    input  wire logic [asa_pkg::ALIGN_W-1:0]               alignment,
    input  wire logic [$clog2(ARENA_BYTES+1)-1:0]          fill,
    input  wire logic [$clog2(STACK_DEPTH+1)-1:0]          count,
    output      logic [asa_pkg::STATUS_W-1:0]              status,
    output      asa_pkg::stack_op_t                        op,
    output      logic [$clog2(ARENA_BYTES+1)-1:0]          push_start,
    output      logic [$clog2(ARENA_BYTES+1)-1:0]          push_fill
);

    localparam int OFF_W = $clog2(ARENA_BYTES + 1);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int SUM_W = ((OFF_W > asa_pkg::SIZE_W) ? OFF_W : asa_pkg::SIZE_W) + 1;

    logic [asa_pkg::ALIGN_W-1:0] mask;
    logic                        align_ok;
    logic [SUM_W-1:0]            round_up;
    logic [SUM_W-1:0]            aligned;
    logic [SUM_W-1:0]            block_end;
    logic [SUM_W-1:0]            arena;

    assign mask      = alignment - asa_pkg::ALIGN_W'(1);
    assign align_ok  = (alignment != '0) && ((alignment & mask) == '0) &&
                       (alignment <= asa_pkg::ALIGN_W'(MAX_ALIGN));
    assign arena     = SUM_W'(ARENA_BYTES);
    assign round_up  = SUM_W'(fill) + SUM_W'(mask);
    assign aligned   = round_up & ~SUM_W'(mask);
    assign block_end = aligned + SUM_W'(object_size);

    assign push_start = aligned[OFF_W-1:0];
    assign push_fill  = block_end[OFF_W-1:0];

    always_comb begin
        status = asa_pkg::ST_OK;
        op     = '0;
        case (command)
            asa_pkg::CMD_PUSH: begin
                if (count >= CNT_W'(STACK_DEPTH)) begin
                    status = asa_pkg::ST_STACK_FULL;
                end else if (object_size == '0 || !align_ok) begin
                    status = asa_pkg::ST_BAD_REQUEST;
                end else if (round_up > arena || block_end > arena) begin
                    status = asa_pkg::ST_ARENA_FULL;
                end else begin
                    op.push = 1'b1;
                end
            end
            asa_pkg::CMD_POP: begin
                if (count == '0) begin
                    status = asa_pkg::ST_POP_EMPTY;
                end else begin
                    op.pop = 1'b1;
                end
            end
            asa_pkg::CMD_CLEAR: begin
                op.clear = 1'b1;
            end
            default: begin
                status = asa_pkg::ST_BAD_REQUEST;
            end
        endcase
    end

endmodule

`default_nettype wire

### design/asa_entry_stack.sv
// ============================================================================
// asa_entry_stack
// Block count, fill offset and the entry memory. The two newest entries sit
// in registers; the third newest is prefetched from memory every cycle.
// ============================================================================
`default_nettype none

module asa_entry_stack #(
    parameter int ARENA_BYTES = 4096,
    parameter int STACK_DEPTH = 8
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 step,
    input  wire asa_pkg::stack_op_t                   op,
    input  wire logic [$clog2(ARENA_BYTES+1)-1:0]     push_start,
    input  wire logic [$clog2(ARENA_BYTES+1)-1:0]     push_fill,
    output      logic [$clog2(STACK_DEPTH+1)-1:0]     count,
    output      logic [$clog2(ARENA_BYTES+1)-1:0]     fill,
    output      logic [$clog2(STACK_DEPTH+1)-1:0]     count_next,
    output      logic [$clog2(ARENA_BYTES+1)-1:0]     fill_next,
    output      logic [$clog2(ARENA_BYTES+1)-1:0]     top_start_next,
    output      logic [$clog2(ARENA_BYTES+1)-1:0]     prev_start_next
);

    localparam int OFF_W = $clog2(ARENA_BYTES + 1);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(STACK_DEPTH);

    typedef struct packed {
        logic [OFF_W-1:0] start;
        logic [OFF_W-1:0] marker;
    } entry_t;

    logic [CNT_W-1:0] count_reg;
    logic [OFF_W-1:0] fill_reg;
    entry_t           top_reg, top_next;
    entry_t           prev_reg, prev_next;
    entry_t           third_reg;
    entry_t           mem [STACK_DEPTH];
    logic [CNT_W-1:0] rd_count;
    logic [IDX_W-1:0] rd_addr;

    always_comb begin
        count_next = count_reg;
        fill_next  = fill_reg;
        top_next   = top_reg;
        prev_next  = prev_reg;
        if (step) begin
            if (op.push) begin
                count_next      = count_reg + CNT_W'(1);
                fill_next       = push_fill;
                top_next.start  = push_start;
                top_next.marker = fill_reg;
                prev_next       = top_reg;
            end else if (op.pop) begin
                count_next = count_reg - CNT_W'(1);
                fill_next  = top_reg.marker;
                top_next   = prev_reg;
                prev_next  = third_reg;
            end else if (op.clear) begin
                count_next = '0;
                fill_next  = '0;
            end
        end
    end

    assign rd_count = (count_next >= CNT_W'(3)) ? count_next - CNT_W'(3) : '0;
    assign rd_addr  = rd_count[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            fill_reg  <= '0;
        end else begin
            count_reg <= count_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg  <= top_next;
        prev_reg <= prev_next;
    end

    always_ff @(posedge aclk) begin
        if (step && op.push) begin
            mem[count_reg[IDX_W-1:0]] <= {push_start, fill_reg};
        end
        third_reg <= mem[rd_addr];
    end

    assign count           = count_reg;
    assign fill            = fill_reg;
    assign top_start_next  = top_next.start;
    assign prev_start_next = prev_next.start;

endmodule

`default_nettype wire

### tb/tb_top.sv
// ============================================================================
// tb_top
// Stream-level test of the aligned stack allocator core. A directed opener
// hits the refusal paths, exact arena fill and a full stack, then random
// push/pop/clear traffic with noise runs against an in-bench allocator
// model, with random gaps on the input and random stalls on the output.
// ============================================================================
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ARENA     = 4096;
    localparam int ALIGN_MAX = 64;
    localparam int DEPTH     = 8;
    localparam logic [asa_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [asa_pkg::STATUS_W-1:0]  status;
        logic [asa_pkg::OUT_OFF_W-1:0] object_offset;
        logic [asa_pkg::OUT_OFF_W-1:0] top_offset;
        logic                          top_valid;
        logic [asa_pkg::OUT_OFF_W-1:0] previous_offset;
        logic                          previous_valid;
        logic [asa_pkg::LIVE_W-1:0]    live_count;
        logic [asa_pkg::OUT_OFF_W-1:0] used_bytes;
    } alloc_reply_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [asa_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [asa_pkg::OUT_DATA_W-1:0] m_tdata;

    logic [asa_pkg::IN_DATA_W-1:0] request_q[$];
    alloc_reply_t                  reply_q[$];
    int                            error_count = 0;
    int                            checked_count = 0;
    int                            send_gap = 0;
    int                            stall_left = 0;
    bit                            quiet_run = 1'b0;

    // allocator state as seen by the bench
    int arena_fill = 0;
    int live_blocks = 0;
    int block_marker[DEPTH];
    int block_start[DEPTH];

    aligned_stack_allocator_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int gap_len();
        int r;
        if ($urandom_range(0, 149) == 0) begin
            quiet_run = ~quiet_run;
        end
        if (quiet_run) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic alloc_reply_t allocate_step(logic [asa_pkg::IN_DATA_W-1:0] req);
        alloc_reply_t rep;
        logic [asa_pkg::CMD_W-1:0] cmd;
        int size;
        int align;
        int mask;
        int aligned;
        cmd   = req[1:0];
        size  = int'(req[17:2]);
        align = int'(req[33:18]);
        rep   = '0;
        if (cmd == asa_pkg::CMD_PUSH) begin
            if (live_blocks >= DEPTH) begin
                rep.status = asa_pkg::ST_STACK_FULL;
            end else if (size == 0 || align == 0 || (align & (align - 1)) != 0 ||
                         align > ALIGN_MAX) begin
                rep.status = asa_pkg::ST_BAD_REQUEST;
            end else begin
                mask = align - 1;
                aligned = (arena_fill + mask) & ~mask;
                if (arena_fill > ARENA - mask || aligned > ARENA ||
                    size > ARENA - aligned) begin
                    rep.status = asa_pkg::ST_ARENA_FULL;
                end else begin
                    block_marker[live_blocks] = arena_fill;
                    block_start[live_blocks] = aligned;
                    live_blocks++;
                    arena_fill = aligned + size;
                    rep.status = asa_pkg::ST_OK;
                    rep.object_offset = asa_pkg::OUT_OFF_W'(aligned);
                end
            end
        end else if (cmd == asa_pkg::CMD_POP) begin
            if (live_blocks == 0) begin
                rep.status = asa_pkg::ST_POP_EMPTY;
            end else begin
                live_blocks--;
                arena_fill = block_marker[live_blocks];
                rep.status = asa_pkg::ST_OK;
            end
        end else if (cmd == asa_pkg::CMD_CLEAR) begin
            if (live_blocks != 0) begin
                arena_fill = block_marker[0];
            end
            live_blocks = 0;
            rep.status = asa_pkg::ST_OK;
        end else begin
            rep.status = asa_pkg::ST_BAD_REQUEST;
        end
        if (live_blocks >= 1) begin
            rep.top_offset = asa_pkg::OUT_OFF_W'(block_start[live_blocks-1]);
            rep.top_valid = 1'b1;
        end
        if (live_blocks >= 2) begin
            rep.previous_offset = asa_pkg::OUT_OFF_W'(block_start[live_blocks-2]);
            rep.previous_valid = 1'b1;
        end
        rep.live_count = asa_pkg::LIVE_W'(live_blocks);
        rep.used_bytes = asa_pkg::OUT_OFF_W'(arena_fill);
        return rep;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("tb_top: mismatch %s got %0d want %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic check_reply(logic [asa_pkg::OUT_DATA_W-1:0] d, alloc_reply_t want);
        alloc_reply_t got;
        got.status          = d[2:0];
        got.object_offset   = d[15:3];
        got.top_offset      = d[28:16];
        got.top_valid       = d[29];
        got.previous_offset = d[42:30];
        got.previous_valid  = d[43];
        got.live_count      = d[47:44];
        got.used_bytes      = d[60:48];
        if (got.status != want.status)
            report_mismatch("status", got.status, want.status);
        if (got.object_offset != want.object_offset)
            report_mismatch("object_offset", got.object_offset, want.object_offset);
        if (got.top_offset != want.top_offset)
            report_mismatch("top_offset", got.top_offset, want.top_offset);
        if (got.top_valid != want.top_valid)
            report_mismatch("top_valid", got.top_valid, want.top_valid);
        if (got.previous_offset != want.previous_offset)
            report_mismatch("previous_offset", got.previous_offset, want.previous_offset);
        if (got.previous_valid != want.previous_valid)
            report_mismatch("previous_valid", got.previous_valid, want.previous_valid);
        if (got.live_count != want.live_count)
            report_mismatch("live_count", got.live_count, want.live_count);
        if (got.used_bytes != want.used_bytes)
            report_mismatch("used_bytes", got.used_bytes, want.used_bytes);
    endtask

    task automatic add_request(logic [asa_pkg::CMD_W-1:0] cmd, int size, int align);
        request_q.push_back({6'b0, align[15:0], size[15:0], cmd});
    endtask

    // input side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                reply_q.push_back(allocate_step(s_tdata));
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (request_q.size() > 0) begin
                    s_tdata  <= request_q.pop_front();
                    s_tvalid <= 1'b1;
                    send_gap <= gap_len();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // output side
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                checked_count++;
                if (reply_q.size() == 0) begin
                    report_mismatch("unexpected item", 1, 0);
                end else begin
                    check_reply(m_tdata, reply_q.pop_front());
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_tready <= 1'b0;
            end else if ($urandom_range(0, 9) < 2) begin
                stall_left <= gap_len();
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        int r;
        int size;
        int total_items;
        for (int i = 0; i < DEPTH; i++) begin
            block_marker[i] = 0;
            block_start[i] = 0;
        end

        add_request(asa_pkg::CMD_POP, 0, 0);
        add_request(asa_pkg::CMD_CLEAR, 0, 0);
        add_request(CMD_UNUSED, 16'hFFFF, 16'hFFFF);
        add_request(asa_pkg::CMD_PUSH, 0, 1);
        add_request(asa_pkg::CMD_PUSH, 1, 0);
        add_request(asa_pkg::CMD_PUSH, 1, 3);
        add_request(asa_pkg::CMD_PUSH, 1, 128);
        add_request(asa_pkg::CMD_PUSH, 1, 16'h8000);
        add_request(asa_pkg::CMD_PUSH, 16'hFFFF, 1);
        add_request(asa_pkg::CMD_PUSH, 1, 1);
        add_request(asa_pkg::CMD_PUSH, 10, 64);
        add_request(asa_pkg::CMD_PUSH, 5, 16);
        add_request(asa_pkg::CMD_POP, 0, 0);
        add_request(asa_pkg::CMD_PUSH, ARENA - 74, 2);
        add_request(asa_pkg::CMD_PUSH, 1, 1);
        add_request(asa_pkg::CMD_PUSH, 1, 64);
        add_request(asa_pkg::CMD_CLEAR, 0, 0);
        for (int i = 0; i <= DEPTH; i++) begin
            add_request(asa_pkg::CMD_PUSH, 1, 1);
        end

        for (int n = 0; n < 950; n++) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                r = $urandom_range(0, 99);
                if (r < 70) size = $urandom_range(1, 64);
                else if (r < 95) size = $urandom_range(1, 700);
                else size = $urandom_range(1, ARENA);
                add_request(asa_pkg::CMD_PUSH, size, 1 << $urandom_range(0, 6));
            end else if (r < 78) begin
                add_request(asa_pkg::CMD_POP, $urandom_range(0, 16'hFFFF),
                            $urandom_range(0, 16'hFFFF));
            end else if (r < 84) begin
                add_request(asa_pkg::CMD_CLEAR, $urandom_range(0, 16'hFFFF),
                            $urandom_range(0, 16'hFFFF));
            end else if (r < 96) begin
                add_request(asa_pkg::CMD_PUSH, $urandom_range(0, 16'hFFFF),
                            $urandom_range(0, 16'hFFFF));
            end else begin
                add_request(CMD_UNUSED, $urandom_range(0, 16'hFFFF),
                            $urandom_range(0, 16'hFFFF));
            end
        end
        total_items = request_q.size();

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (checked_count < total_items) @(posedge aclk);
        repeat (5) @(posedge aclk);

        if (error_count == 0 && reply_q.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
